// ----- design/crc8pd_pkg.sv -----
`timescale 1ns / 1ps

package crc8pd_pkg;

  localparam int BUFFER_BYTES = 64;
  localparam int COUNT_W      = $clog2(BUFFER_BYTES + 1);

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic CFG_RX_ENABLE = 1'b0;
  localparam logic CFG_TIMEOUT   = 1'b1;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_BYTE     = 3'd1,
    EV_GOOD     = 3'd2,
    EV_CRC_ERR  = 3'd3,
    EV_OVERFLOW = 3'd4
  } event_t;

  typedef struct packed {
    logic [5:0]  body_index;
    logic [7:0]  body_byte;
    logic        body_valid;
    logic [15:0] body_length;
    logic [7:0]  command;
    logic        timeout_restart;
    event_t      event_res;
  } result_t;

  // contribution of each bit of crc ^ data, polynomial 0x07
  localparam logic [7:0] CRC_TERMS [8] = '{
    8'h07, 8'h0E, 8'h1C, 8'h38, 8'h70, 8'hE0, 8'hC7, 8'h89
  };

  function automatic logic [7:0] crc_next(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] x;
    logic [7:0] r;
    x = crc ^ data;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (x[i]) begin
        r = r ^ CRC_TERMS[i];
      end
    end
    return r;
  endfunction

endpackage

// ----- design/crc8pd_core.sv -----
`timescale 1ns / 1ps

module crc8pd_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wen,
  input  logic                  cfg_index,
  input  logic [15:0]           cfg_data,
  input  logic                  item_fire,
  input  logic                  kind,
  input  logic [7:0]            rx_byte,
  output crc8pd_pkg::result_t   res
);

  logic                            rx_enable_r;
  logic [15:0]                     timeout_limit_r;
  logic [crc8pd_pkg::COUNT_W-1:0]  count_r, count_nxt;
  logic [7:0]                      crc_r, crc_nxt;
  logic [7:0]                      command_r, command_nxt;
  logic [15:0]                     length_r, length_nxt;
  logic [15:0]                     idle_r, idle_nxt;

  logic [crc8pd_pkg::COUNT_W-1:0]  count_eff;
  logic [7:0]                      crc_eff;
  logic [16:0]                     pos_ext;
  logic [16:0]                     body_end;
  logic [7:0]                      crc_upd;

  always_comb begin
    count_nxt   = count_r;
    crc_nxt     = crc_r;
    command_nxt = command_r;
    length_nxt  = length_r;
    idle_nxt    = idle_r;
    res         = '0;
    count_eff   = count_r;
    crc_eff     = crc_r;
    pos_ext     = 17'(count_r);
    body_end    = 17'(length_r) + 17'd3;
    crc_upd     = crc8pd_pkg::crc_next(crc_r, rx_byte);

    if (kind == crc8pd_pkg::KIND_TICK) begin
      if (idle_r != crc8pd_pkg::TICKS_MAX) begin
        idle_nxt = idle_r + 16'd1;
      end
    end else if (rx_enable_r) begin
      if (idle_r > timeout_limit_r) begin
        res.timeout_restart = 1'b1;
        count_eff = '0;
        crc_eff   = 8'h00;
      end
      pos_ext  = 17'(count_eff);
      crc_upd  = crc8pd_pkg::crc_next(crc_eff, rx_byte);
      idle_nxt = 16'd0;
      if (count_eff >= crc8pd_pkg::COUNT_W'(crc8pd_pkg::BUFFER_BYTES)) begin
        res.event_res = crc8pd_pkg::EV_OVERFLOW;
        count_nxt = '0;
        crc_nxt   = 8'h00;
      end else if (pos_ext == 17'd0) begin
        command_nxt   = rx_byte;
        crc_nxt       = crc_upd;
        count_nxt     = count_eff + 1'b1;
        res.event_res = crc8pd_pkg::EV_BYTE;
      end else if (pos_ext == 17'd1) begin
        length_nxt    = {rx_byte, 8'h00};
        crc_nxt       = crc_upd;
        count_nxt     = count_eff + 1'b1;
        res.event_res = crc8pd_pkg::EV_BYTE;
      end else if (pos_ext == 17'd2) begin
        length_nxt    = {length_r[15:8], rx_byte};
        crc_nxt       = crc_upd;
        count_nxt     = count_eff + 1'b1;
        res.event_res = crc8pd_pkg::EV_BYTE;
      end else if (pos_ext < body_end) begin
        crc_nxt        = crc_upd;
        count_nxt      = count_eff + 1'b1;
        res.event_res  = crc8pd_pkg::EV_BYTE;
        res.body_valid = 1'b1;
        res.body_byte  = rx_byte;
        res.body_index = 6'(pos_ext - 17'd3);
      end else begin
        res.event_res = (rx_byte == crc_eff) ? crc8pd_pkg::EV_GOOD : crc8pd_pkg::EV_CRC_ERR;
        count_nxt = '0;
        crc_nxt   = 8'h00;
      end
    end

    res.command     = command_nxt;
    res.body_length = length_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_enable_r     <= 1'b1;
      timeout_limit_r <= crc8pd_pkg::TIMEOUT_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        crc8pd_pkg::CFG_RX_ENABLE: rx_enable_r     <= cfg_data[0];
        crc8pd_pkg::CFG_TIMEOUT:   timeout_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      crc_r     <= 8'h00;
      command_r <= 8'h00;
      length_r  <= 16'h0000;
      idle_r    <= 16'h0000;
    end else if (item_fire) begin
      count_r   <= count_nxt;
      crc_r     <= crc_nxt;
      command_r <= command_nxt;
      length_r  <= length_nxt;
      idle_r    <= idle_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= crc8pd_pkg::COUNT_W'(crc8pd_pkg::BUFFER_BYTES))
    else $error("byte count beyond buffer size");

  a_body_is_byte: assert property (@(posedge clk) disable iff (!rst_n)
    res.body_valid |-> res.event_res == crc8pd_pkg::EV_BYTE)
    else $error("body byte without byte event");

  a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    item_fire && (res.event_res == crc8pd_pkg::EV_GOOD ||
                  res.event_res == crc8pd_pkg::EV_CRC_ERR ||
                  res.event_res == crc8pd_pkg::EV_OVERFLOW)
    |=> count_r == '0 && crc_r == 8'h00)
    else $error("frame not restarted after end or drop");

  a_tick_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    kind == crc8pd_pkg::KIND_TICK |-> res.event_res == crc8pd_pkg::EV_NONE)
    else $error("tick produced an event");

endmodule

// ----- design/crc8_packet_deframer.sv -----
`timescale 1ns / 1ps
// length-framed packet receiver with crc-8 (poly 0x07, init 0)
// in_*: one transfer per received byte (tuser 0) or timer tick (tuser 1);
//   tdata carries the byte, ignored for ticks
// out_*: exactly one result transfer per input transfer, in order; event code,
//   timeout flag, current command and length, and body byte with its index
// cfg_*: index 0 receive enable, index 1 idle timeout limit; write only while idle
// the result is registered in the output stage before it appears on out_*
// throughput: one item per cycle while in_tready is high; frame state update
//   and crc step are one combinational pass from input handshake to result register
// a two-entry output stage (result register plus skid register) keeps in_tready
//   high while one result waits; with both full in_tready drops until the
//   receiver takes a transfer, and nothing is lost
// reset: synchronous, rst_n low; clears frame state, idle counter and both output
//   entries, receive enable back to 1 and timeout limit to 1000

module crc8_packet_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // command, body_length, body_byte, body_index, zero pad
  output logic [4:0]  out_tuser,  // event_res, timeout_restart, body_valid
  input  logic        cfg_wen,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  crc8pd_pkg::result_t res;
  crc8pd_pkg::result_t out_r, skid_r;
  logic                out_v_r, skid_v_r;
  logic                in_fire, out_fire;

  assign in_tready = !skid_v_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_v_r && out_tready;

  crc8pd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item_fire (in_fire),
    .kind      (in_tuser),
    .rx_byte   (in_tdata),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_fire) begin
      if (skid_v_r) begin
        skid_v_r <= 1'b0;
      end else if (!in_fire) begin
        out_v_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_v_r) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      if (skid_v_r) begin
        out_r <= skid_r;
      end else if (in_fire) begin
        out_r <= res;
      end
    end else if (in_fire) begin
      if (!out_v_r) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, out_r.body_index, out_r.body_byte, out_r.body_length,
                       out_r.command};
  assign out_tuser  = {out_r.body_valid, out_r.timeout_restart, out_r.event_res};

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held without result entry");

  a_input_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !out_fire |=> out_v_r)
    else $error("accepted item left no result");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !out_tready |=> skid_v_r && !in_tready)
    else $error("full output stage released without transfer");

endmodule
